// File: src/bhsv_pkg.sv
package bhsv_pkg;

  localparam int unsigned ChanW         = 8;
  localparam int unsigned HueW          = 15;
  localparam int unsigned SatW          = 13;
  localparam int unsigned HueFracBits   = 6;
  localparam int unsigned SatFracBits   = 12;
  localparam int unsigned NumW          = 11;
  localparam int unsigned QuotW         = 15;
  localparam int unsigned DivW          = QuotW + ChanW;
  localparam int unsigned StepsPerStage = 3;
  localparam int unsigned DivStages     = QuotW / StepsPerStage;
  localparam int unsigned HueScale      = 60 << HueFracBits;
  localparam int unsigned HueLimit      = 360 << HueFracBits;
  localparam int unsigned SatOne        = 1 << SatFracBits;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t            rem;
    logic [QuotW-1:0] dq;
    chan_t            dvs;
  } div_t;

  typedef struct packed {
    div_t  hue;
    div_t  sat;
    chan_t mx;
  } div_stage_t;

  function automatic div_t div_init(logic [DivW-1:0] dividend, chan_t dvs);
    div_t r;
    r.rem = dividend[DivW-1:QuotW];
    r.dq  = dividend[QuotW-1:0];
    r.dvs = dvs;
    return r;
  endfunction

  function automatic div_t div_steps(div_t a);
    div_t       r;
    logic [ChanW:0] t;
    logic       qbit;
    r = a;
    for (int i = 0; i < StepsPerStage; i++) begin
      t    = {r.rem, r.dq[QuotW-1]};
      qbit = (t >= {1'b0, r.dvs});
      if (qbit) begin
        t = t - {1'b0, r.dvs};
      end
      r.rem = t[ChanW-1:0];
      r.dq  = {r.dq[QuotW-2:0], qbit};
    end
    return r;
  endfunction

endpackage

// File: src/bhsv_if.sv
interface bhsv_pix_if import bhsv_pkg::*;;
  logic  valid;
  logic  ready;
  chan_t blue;
  chan_t green;
  chan_t red;

  modport source (output valid, blue, green, red, input ready);
  modport sink (input valid, blue, green, red, output ready);
endinterface

interface bhsv_hsv_if import bhsv_pkg::*;;
  logic            valid;
  logic            ready;
  logic [HueW-1:0] hue;
  logic [SatW-1:0] saturation;
  chan_t           brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

// File: src/bgr_to_hsv_pixel_core.sv
// Channel  Direction  Payload                                 Handshake
// pix_i    in         blue, green, red (8 bits each)          valid/ready
// hsv_o    out        hue (15), saturation (13), brightness (8) valid/ready
//
// One item is taken every cycle while the output is ready; 3 stages hold the input,
// min/max with numerator, and scaling, then 5 divider stages at 3 quotient bits each.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds while the one after it is full and stalled, so a stall
// fills bubbles before it stops the input.
module bgr_to_hsv_pixel_core import bhsv_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  bhsv_pix_if.sink    pix_i,
  bhsv_hsv_if.source  hsv_o
);

  localparam int unsigned NumStages = 3 + DivStages;

  logic [NumStages-1:0] v_q, v_d, en;

  chan_t            b0_q, g0_q, r0_q;
  chan_t            mx1_d, mn1, delta1_d, mx1_q, delta1_q;
  logic [NumW-1:0]  num1_d, num1_q;
  div_stage_t       div_q [DivStages+1];
  div_stage_t       div_d [DivStages+1];

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || hsv_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = pix_i.valid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_comb begin
    logic [NumW-1:0] dx;
    mx1_d = b0_q;
    if (g0_q > mx1_d) mx1_d = g0_q;
    if (r0_q > mx1_d) mx1_d = r0_q;
    mn1 = b0_q;
    if (g0_q < mn1) mn1 = g0_q;
    if (r0_q < mn1) mn1 = r0_q;
    delta1_d = mx1_d - mn1;
    dx = NumW'(delta1_d);
    if (b0_q == mx1_d) begin
      num1_d = (dx << 2) + NumW'(r0_q) - NumW'(g0_q);
    end else if (g0_q == mx1_d) begin
      num1_d = (dx << 1) + NumW'(b0_q) - NumW'(r0_q);
    end else if (g0_q >= b0_q) begin
      num1_d = NumW'(g0_q) - NumW'(b0_q);
    end else begin
      num1_d = (dx << 2) + (dx << 1) + NumW'(g0_q) - NumW'(b0_q);
    end
  end

  always_comb begin
    logic [DivW-1:0] hue_dividend;
    logic [DivW-1:0] sat_dividend;
    chan_t           hue_dvs;
    chan_t           sat_dvs;
    hue_dividend = DivW'(num1_q) * DivW'(HueScale);
    sat_dividend = DivW'(delta1_q) << SatFracBits;
    hue_dvs      = (delta1_q == '0) ? chan_t'(1) : delta1_q;
    sat_dvs      = (mx1_q == '0) ? chan_t'(1) : mx1_q;
    if (delta1_q == '0) begin
      hue_dividend = '0;
    end
    div_d[0].hue = div_init(hue_dividend, hue_dvs);
    div_d[0].sat = div_init(sat_dividend, sat_dvs);
    div_d[0].mx  = mx1_q;
    for (int j = 1; j <= DivStages; j++) begin
      div_d[j].hue = div_steps(div_q[j-1].hue);
      div_d[j].sat = div_steps(div_q[j-1].sat);
      div_d[j].mx  = div_q[j-1].mx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      b0_q <= pix_i.blue;
      g0_q <= pix_i.green;
      r0_q <= pix_i.red;
    end
    if (en[1]) begin
      mx1_q    <= mx1_d;
      delta1_q <= delta1_d;
      num1_q   <= num1_d;
    end
    for (int j = 0; j <= DivStages; j++) begin
      if (en[2+j]) begin
        div_q[j] <= div_d[j];
      end
    end
  end

  assign pix_i.ready      = en[0];
  assign hsv_o.valid      = v_q[NumStages-1];
  assign hsv_o.hue        = div_q[DivStages].hue.dq;
  assign hsv_o.saturation = div_q[DivStages].sat.dq[SatW-1:0];
  assign hsv_o.brightness = div_q[DivStages].mx;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> pix_i.ready)
    else $error("input stalled while the first stage is empty");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (32'(hsv_o.hue) < HueLimit))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (32'(hsv_o.saturation) <= SatOne))
    else $error("saturation above one");

  a_black_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && hsv_o.brightness == '0) |->
      (hsv_o.saturation == '0 && hsv_o.hue == '0))
    else $error("black pixel with nonzero hue or saturation");

endmodule

// File: test/bgr_to_hsv_pixel_core_tb.sv
module bgr_to_hsv_pixel_core_tb;
  import bhsv_pkg::*;

  localparam int unsigned NumDirected = 20;
  localparam int unsigned PhaseItems  = 330;
  localparam int unsigned NumPhases   = 3;
  localparam int unsigned HoldAtItem  = 100;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SatW-1:0] sat;
    chan_t           val;
  } hsv_t;

  typedef struct packed {
    pixel_t px;
    logic   known;
    hsv_t   want;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  bhsv_pix_if pix();
  bhsv_hsv_if hsv();

  bgr_to_hsv_pixel_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .hsv_o  (hsv)
  );

  // Rows with known = 1 carry a result that is obvious by hand: black, gray, white,
  // the pure primaries and the tie cases. The others go through the predictor.
  directed_row_t directed_rows [NumDirected] = '{
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{15'd0,     13'd0,    8'd0  }},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{15'd0,     13'd0,    8'd255}},
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{15'd0,     13'd0,    8'd128}},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{15'd0,     13'd4096, 8'd255}},
    '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{15'd7680,  13'd4096, 8'd255}},
    '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{15'd15360, 13'd4096, 8'd255}},
    '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{15'd11520, 13'd4096, 8'd255}},
    '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{15'd3840,  13'd4096, 8'd255}},
    '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{15'd19200, 13'd4096, 8'd255}},
    '{'{8'd1,   8'd0,   8'd255}, 1'b0, '0},
    '{'{8'd0,   8'd0,   8'd1  }, 1'b1, '{15'd0,     13'd4096, 8'd1  }},
    '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
    '{'{8'd1,   8'd1,   8'd1  }, 1'b1, '{15'd0,     13'd0,    8'd1  }},
    '{'{8'd255, 8'd254, 8'd255}, 1'b0, '0},
    '{'{8'd0,   8'd1,   8'd0  }, 1'b1, '{15'd7680,  13'd4096, 8'd1  }},
    '{'{8'd10,  8'd20,  8'd200}, 1'b0, '0},
    '{'{8'd200, 8'd100, 8'd150}, 1'b0, '0},
    '{'{8'd255, 8'd254, 8'd253}, 1'b0, '0},
    '{'{8'd170, 8'd85,  8'd51 }, 1'b0, '0},
    '{'{8'd85,  8'd170, 8'd204}, 1'b0, '0}
  };

  hsv_t        hsv_expected_q[$];
  logic        pix_known;
  hsv_t        pix_want;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned holds_asked;
  int unsigned holds_done;
  int unsigned pixels_in;
  int unsigned results_out;
  int unsigned bad_results;
  int unsigned quiet_cycles;

  function automatic hsv_t bgr_to_hsv(pixel_t px);
    int   b;
    int   g;
    int   r;
    int   mx;
    int   mn;
    int   delta;
    int   num;
    hsv_t res;
    b     = int'(px.blue);
    g     = int'(px.green);
    r     = int'(px.red);
    mx    = (b > g) ? b : g;
    mx    = (r > mx) ? r : mx;
    mn    = (b < g) ? b : g;
    mn    = (r < mn) ? r : mn;
    delta = mx - mn;
    res   = '0;
    res.val = chan_t'(mx);
    if (delta != 0) begin
      if (b == mx) begin
        num = 4 * delta + r - g;
      end else if (g == mx) begin
        num = 2 * delta + b - r;
      end else if (g >= b) begin
        num = g - b;
      end else begin
        num = 6 * delta + g - b;
      end
      res.hue = HueW'((int'(HueScale) * num) / delta);
    end
    if (mx != 0) begin
      res.sat = SatW'((int'(SatOne) * delta) / mx);
    end
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t      px;
    chan_t       hi;
    chan_t       lo;
    chan_t       ends [4];
    int unsigned kind;
    ends = '{8'd0, 8'd1, 8'd254, 8'd255};
    kind = $urandom_range(9);
    hi   = chan_t'($urandom_range(255));
    lo   = chan_t'($urandom_range(hi));
    px   = 24'($urandom);
    case (kind)
      4: begin
        px = '{hi, hi, hi};
      end
      5: begin
        case ($urandom_range(2))
          0: px = '{hi, hi, lo};
          1: px = '{hi, lo, hi};
          default: px = '{lo, hi, hi};
        endcase
      end
      6: begin
        lo = (hi > 3) ? chan_t'(hi - $urandom_range(3)) : 8'd0;
        case ($urandom_range(2))
          0: px = '{hi, lo, chan_t'($urandom_range(lo, hi))};
          1: px = '{lo, hi, chan_t'($urandom_range(lo, hi))};
          default: px = '{chan_t'($urandom_range(lo, hi)), lo, hi};
        endcase
      end
      7: begin
        px = '{ends[$urandom_range(3)], ends[$urandom_range(3)], ends[$urandom_range(3)]};
      end
      8: begin
        px = '{(lo < hi) ? chan_t'(lo + 1) : lo, lo, hi};
      end
      default: begin
      end
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px, input logic known, input hsv_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.blue  <= px.blue;
    pix.green <= px.green;
    pix.red   <= px.red;
    pix_known <= known;
    pix_want  <= want;
    do @(posedge clk_i); while (pix.ready !== 1'b1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    hsv.ready  = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        for (int i = 0; i < LongHold; i++) begin
          hsv.ready <= 1'b0;
          @(posedge clk_i);
        end
        holds_done++;
      end
      hsv.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    hsv_t want;
    if (pix.valid === 1'b1 && pix.ready === 1'b1) begin
      pixels_in++;
      hsv_expected_q.push_back(pix_known ? pix_want :
                               bgr_to_hsv(pixel_t'{pix.blue, pix.green, pix.red}));
    end
    if (hsv.valid === 1'b1 && hsv.ready === 1'b1) begin
      results_out++;
      if (hsv_expected_q.size() == 0) begin
        bad_results++;
        if (bad_results <= MaxReports) begin
          $display("Unexpected result: hue %0d sat %0d val %0d",
                   hsv.hue, hsv.saturation, hsv.brightness);
        end
      end else begin
        want = hsv_expected_q.pop_front();
        if (hsv.hue !== want.hue || hsv.saturation !== want.sat ||
            hsv.brightness !== want.val) begin
          bad_results++;
          if (bad_results <= MaxReports) begin
            $display("Mismatch: hue %0d/%0d sat %0d/%0d val %0d/%0d (expected/actual)",
                     want.hue, hsv.hue, want.sat, hsv.saturation,
                     want.val, hsv.brightness);
          end
        end
      end
    end
    if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
        (hsv.valid === 1'b1 && hsv.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout after %0d cycles without an accepted item.", quiet_cycles);
      $display("FAIL bgr_to_hsv_pixel_core");
      $finish;
    end
  end

  initial begin
    int unsigned send_pcts [NumPhases];
    int unsigned recv_pcts [NumPhases];
    send_pcts     = '{23, 75, 0};
    recv_pcts     = '{75, 23, 0};
    pix.valid     = 1'b0;
    pix.blue      = '0;
    pix.green     = '0;
    pix.red       = '0;
    pix_known     = 1'b0;
    pix_want      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked   = 0;
    pixels_in     = 0;
    results_out   = 0;
    bad_results   = 0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      pix.valid <= 1'b0;
      do @(posedge clk_i); while (hsv_expected_q.size() != 0);
      send_idle_pct = send_pcts[p];
      recv_idle_pct = recv_pcts[p];
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == NumPhases - 1 && n == HoldAtItem) begin
          holds_asked++;
        end
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    pix.valid <= 1'b0;
    do @(posedge clk_i); while (hsv_expected_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Converted %0d pixels, directed corners and ties then random mixes,", pixels_in);
    $display("under sender and receiver stalls and one long output hold; %0d errors.",
             bad_results);
    if (bad_results == 0) begin
      $display("PASS bgr_to_hsv_pixel_core");
    end else begin
      $display("FAIL bgr_to_hsv_pixel_core");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bhsv_pkg.sv
src/bhsv_if.sv
src/bgr_to_hsv_pixel_core.sv
test/bgr_to_hsv_pixel_core_tb.sv
